// ===== design/srw_pkg.sv =====
// shared types, constants and codes of the synapse rewiring engine
package srw_pkg;

    localparam int MAX_NEURONS      = 256;
    localparam int MAX_CONNECTIONS  = 16;
    localparam int MAX_BLOCK_SPIKES = 64;
    localparam int NUM_SOURCES      = 1024;

    localparam int SRC_W      = $clog2(NUM_SOURCES);
    localparam int NEURON_W   = 8;
    localparam int SLOT_W     = 4;
    localparam int ACT_W      = 3;
    localparam int STAT_W     = 3;
    localparam int CONN_CFG_W = 5;
    localparam int NEUR_CFG_W = 9;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W  = 1;

    localparam int CONN_CFG_RESET = 16;
    localparam int NEUR_CFG_RESET = 256;

    localparam int TBL_DEPTH = MAX_NEURONS * MAX_CONNECTIONS;
    localparam int TBL_AW    = $clog2(TBL_DEPTH);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CONNECTIONS = 1'b0,
        CFG_NEURONS     = 1'b1
    } cfg_index_t;

    typedef enum logic [ACT_W-1:0] {
        ACT_CLEAR  = 3'd0,
        ACT_APPEND = 3'd1,
        ACT_LEARN  = 3'd2,
        ACT_WRITE  = 3'd3,
        ACT_READ   = 3'd4
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_FULL      = 3'd1,
        STAT_NO_UNUSED = 3'd2,
        STAT_NO_NEW    = 3'd3,
        STAT_RANGE     = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_ROW,
        S_SPIKES,
        S_FLUSH,
        S_DECIDE,
        S_READ_WAIT,
        S_RESP
    } seq_state_t;

    typedef struct packed {
        logic [ACT_W-1:0]    action;
        logic [SRC_W-1:0]    spike_source;
        logic [NEURON_W-1:0] neuron;
        logic [SLOT_W-1:0]   slot;
        logic [SRC_W-1:0]    entry_value;
    } in_item_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              replaced;
        logic [SLOT_W-1:0] replaced_slot;
        logic [SRC_W-1:0]  old_source;
        logic [SRC_W-1:0]  new_source;
        logic [SRC_W-1:0]  read_value;
    } out_item_t;

    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [TBL_AW-1:0] addr;
        logic [SRC_W-1:0]  wr_data;
    } tbl_req_t;

    typedef struct packed {
        logic             clear;
        logic             append;
        logic             rd_en;
        logic [SRC_W-1:0] append_src;
    } spk_cmd_t;

    typedef struct packed {
        logic              clear;
        logic              load;
        logic [SLOT_W-1:0] load_slot;
        logic              cmp;
    } match_ctrl_t;

    typedef struct packed {
        logic              found_unused;
        logic [SLOT_W-1:0] unused_slot;
        logic [SRC_W-1:0]  old_source;
        logic              found_new;
        logic [SRC_W-1:0]  new_source;
    } match_stat_t;

endpackage

// ===== design/srw_table.sv =====
// connection table memory, one port, registered read data
module srw_table (
    input  logic                        aclk,
    input  srw_pkg::tbl_req_t           req,
    output logic [srw_pkg::SRC_W-1:0]   rd_data
);

    logic [srw_pkg::SRC_W-1:0] mem [srw_pkg::TBL_DEPTH];
    logic [srw_pkg::SRC_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[req.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/srw_spikes.sv =====
// spike list memory of the current block and its fill count
module srw_spikes #(
    parameter int MAX_BLOCK_SPIKES = srw_pkg::MAX_BLOCK_SPIKES,
    localparam int SPK_AW = $clog2(MAX_BLOCK_SPIKES),
    localparam int CNT_W  = $clog2(MAX_BLOCK_SPIKES + 1)
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  srw_pkg::spk_cmd_t         cmd,
    input  logic [SPK_AW-1:0]         rd_addr,
    output logic [CNT_W-1:0]          count,
    output logic [srw_pkg::SRC_W-1:0] rd_data
);

    logic [srw_pkg::SRC_W-1:0] mem [MAX_BLOCK_SPIKES];
    logic [srw_pkg::SRC_W-1:0] rd_data_reg;
    logic [CNT_W-1:0]          count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.clear) begin
            count_reg <= '0;
        end else if (cmd.append) begin
            count_reg <= count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.append) begin
            mem[count_reg[SPK_AW-1:0]] <= cmd.append_src;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign count   = count_reg;
    assign rd_data = rd_data_reg;

endmodule

// ===== design/srw_match.sv =====
// row register bank with shared compare unit, hit tracking and first-unused search
module srw_match (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  srw_pkg::match_ctrl_t           ctrl,
    input  logic [srw_pkg::SRC_W-1:0]      row_data,
    input  logic [srw_pkg::SRC_W-1:0]      spike_data,
    input  logic [srw_pkg::CONN_CFG_W-1:0] used,
    output srw_pkg::match_stat_t           stat
);

    logic [srw_pkg::SRC_W-1:0]           row_reg [srw_pkg::MAX_CONNECTIONS];
    logic [srw_pkg::MAX_CONNECTIONS-1:0] hit_reg;
    logic [srw_pkg::MAX_CONNECTIONS-1:0] in_use;
    logic [srw_pkg::MAX_CONNECTIONS-1:0] match_vec;
    logic                                found_new_reg;
    logic [srw_pkg::SRC_W-1:0]           new_src_reg;
    logic                                first_new;
    logic                                found_unused;
    logic [srw_pkg::SLOT_W-1:0]          unused_slot;

    always_comb begin
        for (int i = 0; i < srw_pkg::MAX_CONNECTIONS; i++) begin
            in_use[i]    = srw_pkg::CONN_CFG_W'(i) < used;
            match_vec[i] = in_use[i] && (row_reg[i] == spike_data);
        end
    end

    assign first_new = ctrl.cmp && !found_new_reg && (match_vec == '0);

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            row_reg[ctrl.load_slot] <= row_data;
        end
        if (first_new) begin
            new_src_reg <= spike_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            hit_reg       <= '0;
            found_new_reg <= 1'b0;
        end else if (ctrl.cmp) begin
            hit_reg <= hit_reg | match_vec;
            if (first_new) begin
                found_new_reg <= 1'b1;
            end
        end
    end

    // lowest used slot whose source never matched a spike
    always_comb begin
        found_unused = 1'b0;
        unused_slot  = '0;
        for (int i = srw_pkg::MAX_CONNECTIONS - 1; i >= 0; i--) begin
            if (in_use[i] && !hit_reg[i]) begin
                found_unused = 1'b1;
                unused_slot  = srw_pkg::SLOT_W'(i);
            end
        end
    end

    assign stat.found_unused = found_unused;
    assign stat.unused_slot  = unused_slot;
    assign stat.old_source   = row_reg[unused_slot];
    assign stat.found_new    = found_new_reg;
    assign stat.new_source   = new_src_reg;

endmodule

// ===== design/srw_seq.sv =====
// sequencer: handshakes, configuration registers and per-action control
module srw_seq #(
    parameter int MAX_BLOCK_SPIKES = srw_pkg::MAX_BLOCK_SPIKES,
    localparam int SPK_AW = $clog2(MAX_BLOCK_SPIKES),
    localparam int CNT_W  = $clog2(MAX_BLOCK_SPIKES + 1)
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  srw_pkg::in_item_t                s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output srw_pkg::out_item_t               m_data,
    input  logic                             cfg_wr_en,
    input  logic [srw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [srw_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    output srw_pkg::tbl_req_t                tbl_req,
    input  logic [srw_pkg::SRC_W-1:0]        tbl_rd_data,
    output srw_pkg::spk_cmd_t                spk_cmd,
    output logic [SPK_AW-1:0]                spk_rd_addr,
    input  logic [CNT_W-1:0]                 spk_count,
    output srw_pkg::match_ctrl_t             mctrl,
    input  srw_pkg::match_stat_t             mstat,
    output logic [srw_pkg::CONN_CFG_W-1:0]   used
);

    function automatic logic [srw_pkg::TBL_AW-1:0] tbl_addr(
        input logic [srw_pkg::NEURON_W-1:0] neuron,
        input logic [srw_pkg::SLOT_W-1:0]   slot
    );
        return srw_pkg::TBL_AW'(int'(neuron) * srw_pkg::MAX_CONNECTIONS + int'(slot));
    endfunction

    srw_pkg::seq_state_t              state_reg, state_next;
    srw_pkg::in_item_t                item_reg, item_next;
    srw_pkg::out_item_t               res_reg, res_next;
    srw_pkg::out_item_t               out_reg, out_next;
    logic                             m_valid_reg, m_valid_next;
    logic                             s_ready_reg;
    logic [srw_pkg::SLOT_W-1:0]       row_idx_reg, row_idx_next;
    logic [SPK_AW-1:0]                spk_idx_reg, spk_idx_next;
    logic                             ld_pend_reg, ld_pend_next;
    logic [srw_pkg::SLOT_W-1:0]       ld_slot_reg, ld_slot_next;
    logic                             cmp_pend_reg, cmp_pend_next;
    logic [srw_pkg::CONN_CFG_W-1:0]   conn_cfg_reg;
    logic [srw_pkg::NEUR_CFG_W-1:0]   neur_cfg_reg;
    logic [srw_pkg::NEUR_CFG_W-1:0]   eff_neur;
    logic                             neuron_ok;

    assign used = (conn_cfg_reg > srw_pkg::CONN_CFG_W'(srw_pkg::MAX_CONNECTIONS))
                ? srw_pkg::CONN_CFG_W'(srw_pkg::MAX_CONNECTIONS) : conn_cfg_reg;
    assign eff_neur = (neur_cfg_reg > srw_pkg::NEUR_CFG_W'(srw_pkg::MAX_NEURONS))
                    ? srw_pkg::NEUR_CFG_W'(srw_pkg::MAX_NEURONS) : neur_cfg_reg;
    assign neuron_ok = srw_pkg::NEUR_CFG_W'(item_reg.neuron) < eff_neur;

    assign spk_rd_addr = spk_idx_reg;

    always_comb begin
        state_next    = state_reg;
        item_next     = item_reg;
        res_next      = res_reg;
        out_next      = out_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        row_idx_next  = row_idx_reg;
        spk_idx_next  = spk_idx_reg;
        ld_pend_next  = 1'b0;
        ld_slot_next  = row_idx_reg;
        cmp_pend_next = 1'b0;
        tbl_req       = '0;
        spk_cmd       = '0;
        mctrl.clear     = 1'b0;
        mctrl.load      = ld_pend_reg;
        mctrl.load_slot = ld_slot_reg;
        mctrl.cmp       = cmp_pend_reg;

        unique case (state_reg)
            srw_pkg::S_IDLE: begin
                if (s_valid && s_ready_reg) begin
                    item_next  = s_data;
                    state_next = srw_pkg::S_DISPATCH;
                end
            end
            srw_pkg::S_DISPATCH: begin
                res_next   = '0;
                state_next = srw_pkg::S_RESP;
                unique case (item_reg.action)
                    srw_pkg::ACT_CLEAR: begin
                        spk_cmd.clear = 1'b1;
                    end
                    srw_pkg::ACT_APPEND: begin
                        if (spk_count == CNT_W'(MAX_BLOCK_SPIKES)) begin
                            res_next.status = srw_pkg::STAT_FULL;
                        end else begin
                            spk_cmd.append     = 1'b1;
                            spk_cmd.append_src = item_reg.spike_source;
                        end
                    end
                    srw_pkg::ACT_LEARN: begin
                        if (!neuron_ok) begin
                            res_next.status = srw_pkg::STAT_RANGE;
                        end else begin
                            mctrl.clear  = 1'b1;
                            row_idx_next = '0;
                            state_next   = srw_pkg::S_ROW;
                        end
                    end
                    srw_pkg::ACT_WRITE: begin
                        if (!neuron_ok) begin
                            res_next.status = srw_pkg::STAT_RANGE;
                        end else if (int'(item_reg.slot) < srw_pkg::MAX_CONNECTIONS) begin
                            tbl_req.wr_en   = 1'b1;
                            tbl_req.addr    = tbl_addr(item_reg.neuron, item_reg.slot);
                            tbl_req.wr_data = item_reg.entry_value;
                        end
                    end
                    srw_pkg::ACT_READ: begin
                        if (!neuron_ok) begin
                            res_next.status = srw_pkg::STAT_RANGE;
                        end else if (int'(item_reg.slot) < srw_pkg::MAX_CONNECTIONS) begin
                            tbl_req.rd_en = 1'b1;
                            tbl_req.addr  = tbl_addr(item_reg.neuron, item_reg.slot);
                            state_next    = srw_pkg::S_READ_WAIT;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            srw_pkg::S_READ_WAIT: begin
                res_next.read_value = tbl_rd_data;
                state_next          = srw_pkg::S_RESP;
            end
            srw_pkg::S_ROW: begin
                tbl_req.rd_en = 1'b1;
                tbl_req.addr  = tbl_addr(item_reg.neuron, row_idx_reg);
                ld_pend_next  = 1'b1;
                row_idx_next  = row_idx_reg + srw_pkg::SLOT_W'(1);
                if (row_idx_reg == srw_pkg::SLOT_W'(srw_pkg::MAX_CONNECTIONS - 1)) begin
                    spk_idx_next = '0;
                    state_next   = (spk_count == '0) ? srw_pkg::S_FLUSH : srw_pkg::S_SPIKES;
                end
            end
            srw_pkg::S_SPIKES: begin
                spk_cmd.rd_en = 1'b1;
                cmp_pend_next = 1'b1;
                spk_idx_next  = spk_idx_reg + SPK_AW'(1);
                if (CNT_W'(spk_idx_reg) + CNT_W'(1) == spk_count) begin
                    state_next = srw_pkg::S_FLUSH;
                end
            end
            srw_pkg::S_FLUSH: begin
                state_next = srw_pkg::S_DECIDE;
            end
            srw_pkg::S_DECIDE: begin
                state_next = srw_pkg::S_RESP;
                if (!mstat.found_unused) begin
                    res_next.status = srw_pkg::STAT_NO_UNUSED;
                end else if (!mstat.found_new) begin
                    res_next.status = srw_pkg::STAT_NO_NEW;
                end else begin
                    res_next.replaced      = 1'b1;
                    res_next.replaced_slot = mstat.unused_slot;
                    res_next.old_source    = mstat.old_source;
                    res_next.new_source    = mstat.new_source;
                    tbl_req.wr_en          = 1'b1;
                    tbl_req.addr           = tbl_addr(item_reg.neuron, mstat.unused_slot);
                    tbl_req.wr_data        = mstat.new_source;
                end
            end
            srw_pkg::S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    out_next     = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = srw_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = srw_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= srw_pkg::S_IDLE;
            s_ready_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
            ld_pend_reg  <= 1'b0;
            cmp_pend_reg <= 1'b0;
            conn_cfg_reg <= srw_pkg::CONN_CFG_W'(srw_pkg::CONN_CFG_RESET);
            neur_cfg_reg <= srw_pkg::NEUR_CFG_W'(srw_pkg::NEUR_CFG_RESET);
        end else begin
            state_reg    <= state_next;
            s_ready_reg  <= (state_next == srw_pkg::S_IDLE);
            m_valid_reg  <= m_valid_next;
            ld_pend_reg  <= ld_pend_next;
            cmp_pend_reg <= cmp_pend_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    srw_pkg::CFG_CONNECTIONS: begin
                        conn_cfg_reg <= cfg_wr_data[srw_pkg::CONN_CFG_W-1:0];
                    end
                    srw_pkg::CFG_NEURONS: begin
                        neur_cfg_reg <= cfg_wr_data[srw_pkg::NEUR_CFG_W-1:0];
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        item_reg    <= item_next;
        res_reg     <= res_next;
        out_reg     <= out_next;
        row_idx_reg <= row_idx_next;
        spk_idx_reg <= spk_idx_next;
        ld_slot_reg <= ld_slot_next;
    end

    assign s_ready = s_ready_reg;
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

// ===== design/synapse_rewiring_engine_top.sv =====
// top level of the synapse rewiring engine
//
//  port group   direction  handshake            payload
//  s_*          in         s_valid / s_ready    s_data      (srw_pkg::in_item_t)
//  m_*          out        m_valid / m_ready    m_data      (srw_pkg::out_item_t)
//  cfg_*        in         cfg_wr_en            cfg_index, cfg_wr_data
//
//  one transaction at a time; clear, append and write pass dispatch and
//  response, a read adds a read wait, and learn adds row load, spike compare,
//  flush and decide: the single table port loads the row, then
//  the spike list port feeds one spike a cycle into the shared compare bank.
//  reset clears the spike count and loads the register defaults; the table
//  and spike list are not cleared, so there is no clearing pass.
//  a result waiting on m_ready holds in the output register while the next
//  transaction is accepted and worked up to its own hand-off.
module synapse_rewiring_engine_top #(
    parameter int MAX_BLOCK_SPIKES = srw_pkg::MAX_BLOCK_SPIKES
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  srw_pkg::in_item_t              s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output srw_pkg::out_item_t             m_data,
    input  logic                           cfg_wr_en,
    input  logic [srw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [srw_pkg::CFG_DATA_W-1:0] cfg_wr_data
);

    localparam int SPK_AW = $clog2(MAX_BLOCK_SPIKES);
    localparam int CNT_W  = $clog2(MAX_BLOCK_SPIKES + 1);

    srw_pkg::tbl_req_t              tbl_req;
    logic [srw_pkg::SRC_W-1:0]      tbl_rd_data;
    srw_pkg::spk_cmd_t              spk_cmd;
    logic [SPK_AW-1:0]              spk_rd_addr;
    logic [CNT_W-1:0]               spk_count;
    logic [srw_pkg::SRC_W-1:0]      spk_rd_data;
    srw_pkg::match_ctrl_t           mctrl;
    srw_pkg::match_stat_t           mstat;
    logic [srw_pkg::CONN_CFG_W-1:0] used;

    srw_table u_table (
        .aclk    (aclk),
        .req     (tbl_req),
        .rd_data (tbl_rd_data)
    );

    srw_spikes #(
        .MAX_BLOCK_SPIKES (MAX_BLOCK_SPIKES)
    ) u_spikes (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (spk_cmd),
        .rd_addr (spk_rd_addr),
        .count   (spk_count),
        .rd_data (spk_rd_data)
    );

    srw_match u_match (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (mctrl),
        .row_data   (tbl_rd_data),
        .spike_data (spk_rd_data),
        .used       (used),
        .stat       (mstat)
    );

    srw_seq #(
        .MAX_BLOCK_SPIKES (MAX_BLOCK_SPIKES)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .tbl_req     (tbl_req),
        .tbl_rd_data (tbl_rd_data),
        .spk_cmd     (spk_cmd),
        .spk_rd_addr (spk_rd_addr),
        .spk_count   (spk_count),
        .mctrl       (mctrl),
        .mstat       (mstat),
        .used        (used)
    );

endmodule

// ===== design/srw_checker.sv =====
// port-level checker for the synapse rewiring engine and its bind
module srw_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input srw_pkg::out_item_t m_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // one transaction in flight: busy right after an accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready right after accept");

    a_no_result_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_replace_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.replaced |-> m_data.status == srw_pkg::STAT_OK
            && m_data.read_value == '0)
        else $error("rewire with bad status");

    a_read_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.read_value != '0) |-> m_data.status == srw_pkg::STAT_OK
            && !m_data.replaced)
        else $error("read data with bad status");

endmodule

bind synapse_rewiring_engine_top srw_checker u_srw_checker (.*);
